[rtl/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and codes for the streaming KMP matcher: transaction payloads,
// opcode and status codes, controller state and the control/status bundles.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Opcodes of an input transaction
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;

    // Status codes of a result transaction
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] match_index;
        logic [6:0]  pattern_length;
        logic [15:0] text_position;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_COMMIT
    } kmp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic step;     // one fallback-chain compare step
        logic commit;   // update state and load the result register
    } kmp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_search;  // offered item has to walk the failure chain
        logic step_done;    // chain walk ends with this compare
    } kmp_status_t;

endpackage

[rtl/kmp_stream_matcher_unit.sv]
// Sequence: an item with no pattern compare goes from accept straight to commit;
//   an item that walks the failure chain passes a read and a compare state per step.
// One item at a time: a new item is accepted only after the last one commits; each
//   step is a registered store read plus the byte compare; a stalled result holds commit.
// Reset: counts, loaded length and the found flag clear; the stores are not
//   cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// kmp_stream_matcher_unit
// Streaming Knuth-Morris-Pratt first-match search: pattern bytes build the
// failure table incrementally, text bytes walk the fallback chain.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_unit
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN     = 64,
    parameter int TEXT_INDEX_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    kmp_cmd_t    cmd;
    kmp_status_t dp_status;

    // Sequencer
    kmp_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .dp_status    (dp_status),
        .cmd          (cmd)
    );

    // Stores, counters and compare unit
    kmp_datapath #(
        .MAX_PATTERN     (MAX_PATTERN),
        .TEXT_INDEX_BITS (TEXT_INDEX_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .dp_status (dp_status),
        .result    (result)
    );

endmodule

[rtl/kmp_ctrl.sv]
// ----------------------------------------------------------------------------
// kmp_ctrl
// Controller: accepts one transaction at a time, sequences the compare loop
// against the pattern store and hands results to the output register.
// ----------------------------------------------------------------------------
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  kmp_status_t dp_status,
    output kmp_cmd_t    cmd
);

    kmp_state_t state_reg;
    kmp_state_t state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       slot_free;

    // Output slot can take a result this cycle
    assign slot_free = !result_valid_reg || !result_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = dp_status.need_search ? ST_READ : ST_COMMIT;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = dp_status.step_done ? ST_COMMIT : ST_READ;
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            ST_CMP:
            begin
                cmd.step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

[rtl/kmp_datapath.sv]
// ----------------------------------------------------------------------------
// kmp_datapath
// Datapath: pattern and failure stores, search counters, the fallback-chain
// compare unit and the result register.
// ----------------------------------------------------------------------------
module kmp_datapath
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN     = 64,
    parameter int TEXT_INDEX_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    item,
    input  kmp_cmd_t    cmd,
    output kmp_status_t dp_status,
    output out_item_t   result
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int TW = TEXT_INDEX_BITS;
    localparam int SW = (TW > LW) ? TW : LW;

    // Stores
    logic [7:0]    pattern_mem [MAX_PATTERN];
    logic [IW-1:0] failure_mem [MAX_PATTERN];

    // Search state
    logic [LW-1:0] loaded_reg,    loaded_next;
    logic [IW-1:0] builder_reg,   builder_next;
    logic [IW-1:0] matched_reg,   matched_next;
    logic [TW-1:0] text_reg,      text_next;
    logic          found_reg,     found_next;
    logic [TW-1:0] first_idx_reg, first_idx_next;

    // Item in flight
    logic [1:0]    op_reg;
    logic [7:0]    byte_reg;
    logic [LW-1:0] k_reg, k_next;
    logic [7:0]    pat_rd_reg;
    logic [IW-1:0] fail_rd_reg;
    out_item_t     result_reg, result_next;

    logic          full;
    logic          sat;
    logic [LW-1:0] k_start;
    logic [IW-1:0] k_m1;
    logic          byte_hit;
    logic          need_search;
    logic          step_done;
    logic [1:0]    stat;
    logic [SW-1:0] idx_wide;

    assign full = (loaded_reg == LW'(MAX_PATTERN));
    assign sat  = &text_reg;
    assign k_m1 = IW'(k_reg - 1'b1);

    // Start point and search decision for the offered item
    always_comb
    begin
        k_start     = '0;
        need_search = 1'b0;
        case (item.opcode)
            OP_APPEND:
            begin
                if (LW'(builder_reg) < loaded_reg)
                begin
                    k_start = LW'(builder_reg);
                end
                need_search = !full && (loaded_reg != '0);
            end
            OP_TEXT:
            begin
                if (LW'(matched_reg) < loaded_reg)
                begin
                    k_start = LW'(matched_reg);
                end
                need_search = !found_reg && !sat && (loaded_reg != '0);
            end
            default:
            begin
                k_start     = '0;
                need_search = 1'b0;
            end
        endcase
    end

    // Compare step along the failure chain
    assign byte_hit  = (pat_rd_reg == byte_reg);
    assign step_done = byte_hit || (k_reg == '0);

    assign dp_status = {need_search, step_done};

    always_comb
    begin
        k_next = k_reg;
        if (cmd.accept)
        begin
            k_next = k_start;
        end
        else if (cmd.step)
        begin
            if (byte_hit)
            begin
                k_next = k_reg + 1'b1;
            end
            else if (k_reg != '0)
            begin
                k_next = LW'(fail_rd_reg);
            end
        end
    end

    // State update on commit
    always_comb
    begin
        loaded_next    = loaded_reg;
        builder_next   = builder_reg;
        matched_next   = matched_reg;
        text_next      = text_reg;
        found_next     = found_reg;
        first_idx_next = first_idx_reg;
        stat           = STAT_OK;
        idx_wide       = SW'(text_reg) + SW'(1) - SW'(loaded_reg);
        case (op_reg)
            OP_CLEAR:
            begin
                loaded_next    = '0;
                builder_next   = '0;
                matched_next   = '0;
                text_next      = '0;
                found_next     = 1'b0;
                first_idx_next = '0;
            end
            OP_APPEND:
            begin
                matched_next   = '0;
                text_next      = '0;
                found_next     = 1'b0;
                first_idx_next = '0;
                if (full)
                begin
                    stat = STAT_FULL;
                end
                else
                begin
                    builder_next = k_reg[IW-1:0];
                    loaded_next  = loaded_reg + 1'b1;
                end
            end
            OP_TEXT:
            begin
                if (found_reg)
                begin
                    stat = STAT_OK;
                end
                else if (sat)
                begin
                    stat = STAT_SAT;
                end
                else
                begin
                    text_next = text_reg + 1'b1;
                    if (loaded_reg == '0)
                    begin
                        // empty pattern matches at the start
                        found_next     = 1'b1;
                        first_idx_next = '0;
                    end
                    else if (k_reg == loaded_reg)
                    begin
                        found_next     = 1'b1;
                        first_idx_next = TW'(idx_wide);
                        matched_next   = '0;
                    end
                    else
                    begin
                        matched_next = k_reg[IW-1:0];
                    end
                end
            end
            default:
            begin
                stat = STAT_OK;
            end
        endcase

        result_next.status         = stat;
        result_next.found          = found_next;
        result_next.match_index    = found_next ? 16'(first_idx_next) : 16'd0;
        result_next.pattern_length = 7'(loaded_next);
        result_next.text_position  = 16'(text_next);
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            builder_reg   <= '0;
            matched_reg   <= '0;
            text_reg      <= '0;
            found_reg     <= 1'b0;
            first_idx_reg <= '0;
        end
        else if (cmd.commit)
        begin
            loaded_reg    <= loaded_next;
            builder_reg   <= builder_next;
            matched_reg   <= matched_next;
            text_reg      <= text_next;
            found_reg     <= found_next;
            first_idx_reg <= first_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.accept)
        begin
            op_reg   <= item.opcode;
            byte_reg <= item.data_byte;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    // Pattern store: written on append, read at the chain position
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (item.opcode == OP_APPEND) && !full)
        begin
            pattern_mem[loaded_reg[IW-1:0]] <= item.data_byte;
        end
        pat_rd_reg <= pattern_mem[k_reg[IW-1:0]];
    end

    // Failure store: written when an append commits
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == OP_APPEND) && !full)
        begin
            failure_mem[loaded_reg[IW-1:0]] <= k_reg[IW-1:0];
        end
        fail_rd_reg <= failure_mem[k_m1];
    end

    assign result = result_reg;

endmodule
